FILE: hdl/cpoq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpoq_pkg
// Shared types and codes for the class priority order queue: the stored
// entry layout, operation and status codes, and scanner control.
// ----------------------------------------------------------------------------
package cpoq_pkg;

  // operation codes
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_POP    = 3'd2;
  localparam logic [2:0] OP_PEEK   = 3'd3;
  localparam logic [2:0] OP_SWAP   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // number of priority classes searched, highest first (1, 2, 3)
  localparam int unsigned NUM_PRIO = 3;

  // one stored entry
  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] tag;
    logic [15:0] army;
  } entry_t;

  // scanner control from the sequencer
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

FILE: hdl/cpoq_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpoq_scan
// Watches entries streamed out of the table in list order and keeps the
// first entry of each priority class plus the head; presents the entry
// that pop and peek select.
// ----------------------------------------------------------------------------
module cpoq_scan import cpoq_pkg::*; #(
  parameter int unsigned PW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scan_ctl_t     ctl_i,
  input  logic [PW-1:0] pos_i,
  input  entry_t        entry_i,
  output logic [PW-1:0] sel_pos_o,
  output entry_t        sel_entry_o
);

  logic   [NUM_PRIO-1:0] found_q;
  logic   [PW-1:0]       pos_q [NUM_PRIO];
  entry_t                ent_q [NUM_PRIO];
  entry_t                head_q;

  // first-hit flags per class
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else if (ctl_i.clear) begin
      found_q <= '0;
    end else if (ctl_i.sample) begin
      for (int c = 0; c < NUM_PRIO; c++) begin
        if (entry_i.cls == 2'(c + 1)) begin
          found_q[c] <= 1'b1;
        end
      end
    end
  end

  // captured position and entry of each first hit
  always_ff @(posedge clk_i) begin
    if (ctl_i.sample) begin
      for (int c = 0; c < NUM_PRIO; c++) begin
        if (!found_q[c] && entry_i.cls == 2'(c + 1)) begin
          pos_q[c] <= pos_i;
          ent_q[c] <= entry_i;
        end
      end
      if (pos_i == '0) begin
        head_q <= entry_i;
      end
    end
  end

  // priority pick, head when no class matched
  always_comb begin
    sel_pos_o   = '0;
    sel_entry_o = head_q;
    for (int c = NUM_PRIO - 1; c >= 0; c--) begin
      if (found_q[c]) begin
        sel_pos_o   = pos_q[c];
        sel_entry_o = ent_q[c];
      end
    end
  end

endmodule

FILE: hdl/class_priority_order_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_priority_order_queue_top
// Ordered list of class/tag/army entries held in a one-port-read,
// one-port-write table, with a sequencer for append, remove, pop, peek, swap.
// ----------------------------------------------------------------------------
// One item is worked at a time; every access goes through the single read
// port of the entry table, whose data arrives in the cycle after the address.
// Append writes at once; remove reads the entry and shifts the later ones
// down; peek streams the list through the scanner, pop also closes the gap
// at the selected entry; swap reads both entries and writes them crosswise.
// The result sits in an output register, so the next item is taken while a
// result still waits. No clearing pass is needed after reset.
module class_priority_order_queue_top import cpoq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [1:0]  entry_class_i,
  input  logic [15:0] entry_tag_i,
  input  logic [15:0] entry_army_i,
  input  logic [3:0]  position_a_i,
  input  logic [3:0]  position_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_tag_o,
  output logic [1:0]  out_class_o,
  output logic [15:0] out_army_o,
  output logic [4:0]  occupancy_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NW = CW + 1;
  localparam int unsigned XW = (CW > 4) ? CW : 4;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RMRD = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_SEL  = 4'd3;
  localparam logic [3:0] S_MOVE = 4'd4;
  localparam logic [3:0] S_SWA  = 4'd5;
  localparam logic [3:0] S_SWB  = 4'd6;
  localparam logic [3:0] S_SWW  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [2:0]    op_q, op_d;
  logic [PW-1:0] a_idx_q, a_idx_d;
  logic [PW-1:0] b_idx_q, b_idx_d;
  entry_t        hold_q, hold_d;
  logic [1:0]    pend_status_q, pend_status_d;
  entry_t        pend_q, pend_d;

  logic          out_valid_q;
  logic [1:0]    out_status_q;
  entry_t        out_q;
  logic [4:0]    out_occ_q;

  // entry table ports
  entry_t        mem_q [DEPTH];
  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr, wr_addr;
  entry_t        wr_data, rdata_q;

  // scanner
  scan_ctl_t     scan_ctl;
  logic [PW-1:0] sel_pos;
  entry_t        sel_entry;

  // gap closing helpers
  logic [PW-1:0] gap_pos;
  logic [NW-1:0] gap_next, move_next;
  logic          load_out, in_fire;
  logic [XW-1:0] pa_x, pb_x, cnt_x;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign pa_x     = XW'(position_a_i);
  assign pb_x     = XW'(position_b_i);
  assign cnt_x    = XW'(count_q);

  assign gap_pos   = (state_q == S_RMRD) ? a_idx_q : sel_pos;
  assign gap_next  = NW'(gap_pos) + NW'(1);
  assign move_next = NW'(ptr_q) + NW'(2);

  cpoq_scan #(
    .PW (PW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .pos_i       (ptr_q),
    .entry_i     (rdata_q),
    .sel_pos_o   (sel_pos),
    .sel_entry_o (sel_entry)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ptr_d         = ptr_q;
    op_d          = op_q;
    a_idx_d       = a_idx_q;
    b_idx_d       = b_idx_q;
    hold_d        = hold_q;
    pend_status_d = pend_status_q;
    pend_d        = pend_q;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rdata_q;
    scan_ctl      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d          = kind_i;
          a_idx_d       = PW'(position_a_i);
          b_idx_d       = PW'(position_b_i);
          pend_status_d = ST_OK;
          pend_d        = '0;
          scan_ctl.clear = 1'b1;
          state_d       = S_DONE;
          case (kind_i)
            OP_APPEND: begin
              if (count_q == CW'(DEPTH)) begin
                pend_status_d = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = count_q[PW-1:0];
                wr_data.cls  = entry_class_i;
                wr_data.tag  = entry_tag_i;
                wr_data.army = entry_army_i;
                count_d      = count_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (count_q == '0) begin
                pend_status_d = ST_EMPTY;
              end else if (pa_x >= cnt_x) begin
                pend_status_d = ST_RANGE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = PW'(position_a_i);
                state_d = S_RMRD;
              end
            end
            OP_POP, OP_PEEK: begin
              if (count_q == '0) begin
                pend_status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            OP_SWAP: begin
              if (count_q == '0) begin
                pend_status_d = ST_EMPTY;
              end else if (pa_x >= cnt_x || pb_x >= cnt_x) begin
                pend_status_d = ST_RANGE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = PW'(position_a_i);
                state_d = S_SWA;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // removed entry arrives, start closing the gap
      S_RMRD: begin
        pend_d.army = rdata_q.army;
        if (gap_next < NW'(count_q)) begin
          rd_en   = 1'b1;
          rd_addr = gap_next[PW-1:0];
          ptr_d   = gap_pos;
          state_d = S_MOVE;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      // stream the list through the scanner
      S_SCAN: begin
        scan_ctl.sample = 1'b1;
        if (NW'(ptr_q) + NW'(1) < NW'(count_q)) begin
          rd_en   = 1'b1;
          rd_addr = ptr_q + PW'(1);
          ptr_d   = ptr_q + PW'(1);
        end else begin
          state_d = S_SEL;
        end
      end

      // report the selected entry, pop also closes its gap
      S_SEL: begin
        pend_d = sel_entry;
        if (op_q == OP_POP) begin
          if (gap_next < NW'(count_q)) begin
            rd_en   = 1'b1;
            rd_addr = gap_next[PW-1:0];
            ptr_d   = gap_pos;
            state_d = S_MOVE;
          end else begin
            count_d = count_q - CW'(1);
            state_d = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      // shift one entry down, read the next one ahead
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = rdata_q;
        ptr_d   = ptr_q + PW'(1);
        if (move_next < NW'(count_q)) begin
          rd_en   = 1'b1;
          rd_addr = move_next[PW-1:0];
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_SWA: begin
        hold_d  = rdata_q;
        rd_en   = 1'b1;
        rd_addr = b_idx_q;
        state_d = S_SWB;
      end

      S_SWB: begin
        wr_en   = 1'b1;
        wr_addr = a_idx_q;
        wr_data = rdata_q;
        state_d = S_SWW;
      end

      S_SWW: begin
        wr_en   = 1'b1;
        wr_addr = b_idx_q;
        wr_data = hold_q;
        state_d = S_DONE;
      end

      // wait for the output register to free up
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    ptr_q         <= ptr_d;
    op_q          <= op_d;
    a_idx_q       <= a_idx_d;
    b_idx_q       <= b_idx_d;
    hold_q        <= hold_d;
    pend_status_q <= pend_status_d;
    pend_q        <= pend_d;
    if (load_out) begin
      out_status_q <= pend_status_q;
      out_q        <= pend_q;
      out_occ_q    <= 5'(count_q);
    end
  end

  // entry table, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_tag_o   = out_q.tag;
  assign out_class_o = out_q.cls;
  assign out_army_o  = out_q.army;
  assign occupancy_o = out_occ_q;

  // fill level never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // a full status is only reported while the table is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && pend_status_q == ST_FULL) |-> count_q == CW'(DEPTH))
    else $error("full status with free entries");

  // table writes stay inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> NW'(wr_addr) < NW'(DEPTH))
    else $error("table write out of range");

  // a shift only runs on a list that holds something
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |-> (count_q != '0 && NW'(ptr_q) + NW'(1) < NW'(count_q)))
    else $error("shift past the tail");

  // an accepted item is followed by a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("item accepted while busy");

endmodule

FILE: test/class_priority_order_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_priority_order_queue_top_tb
// Self-checking bench for the class priority order queue. A short table of
// directed orders covers the empty, full and out-of-range cases first. A long
// run of random orders follows, with fill and drain phases. A local copy of
// the list predicts every result, and each result is checked field by field
// while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module class_priority_order_queue_top_tb import cpoq_pkg::*;;

  localparam int unsigned QDEPTH      = 16;
  localparam int          RAND_ITEMS  = 1560;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          LONG_HOLD   = 300;
  localparam int          DRAIN_WAIT  = 64;
  localparam int          NUM_ROWS    = 25;
  // kinds that the block treats as no operation
  localparam logic [2:0]  OP_NOP_LO   = 3'd5;
  localparam logic [2:0]  OP_NOP_HI   = 3'd7;

  // one order as offered to the block
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  cls;
    logic [15:0] tag;
    logic [15:0] army;
    logic [3:0]  pa;
    logic [3:0]  pb;
  } order_in_t;

  // one result as returned by the block
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag;
    logic [1:0]  cls;
    logic [15:0] army;
    logic [4:0]  occ;
  } order_res_t;

  // directed row; typed rows carry their own status and occupancy
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  cls;
    logic [15:0] tag;
    logic [15:0] army;
    logic [3:0]  pa;
    logic [3:0]  pb;
    logic [4:0]  reps;
    logic        typed;
    logic [1:0]  exp_status;
    logic [4:0]  exp_occ;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i        = OP_APPEND;
  logic [1:0]  entry_class_i = 2'd0;
  logic [15:0] entry_tag_i   = 16'h0000;
  logic [15:0] entry_army_i  = 16'h0000;
  logic [3:0]  position_a_i  = 4'd0;
  logic [3:0]  position_b_i  = 4'd0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] out_tag_o;
  logic [1:0]  out_class_o;
  logic [15:0] out_army_o;
  logic [4:0]  occupancy_o;

  // predicted list contents and pending results
  entry_t     order_list [QDEPTH];
  int         order_count = 0;
  order_res_t expected_q [$];

  dir_row_t   dir_rows [NUM_ROWS];

  int sender_idle_pct = 24;
  int recv_idle_pct   = 57;
  bit stall_hold_req  = 1'b0;
  int hold_left       = 0;
  int cycle_count     = 0;
  int mismatches      = 0;
  int items_sent      = 0;
  int results_seen    = 0;
  int full_hits       = 0;
  int empty_hits      = 0;
  int range_hits      = 0;
  int long_holds      = 0;

  class_priority_order_queue_top #(
    .DEPTH(QDEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .entry_class_i(entry_class_i),
    .entry_tag_i  (entry_tag_i),
    .entry_army_i (entry_army_i),
    .position_a_i (position_a_i),
    .position_b_i (position_b_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_tag_o    (out_tag_o),
    .out_class_o  (out_class_o),
    .out_army_o   (out_army_o),
    .occupancy_o  (occupancy_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // delete one entry of the predicted list and close the gap
  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < order_count; i++) order_list[i] = order_list[i + 1];
    order_count--;
  endfunction

  // apply one order to the predicted list and return its result
  function automatic order_res_t apply_order_op(input order_in_t it);
    order_res_t res;
    entry_t     tmp;
    int         sel;
    bit         found;
    res   = '0;
    sel   = 0;
    found = 1'b0;
    case (it.kind)
      OP_APPEND: begin
        if (order_count >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          order_list[order_count] = '{cls: it.cls, tag: it.tag, army: it.army};
          order_count++;
        end
      end
      OP_REMOVE: begin
        if (order_count == 0) res.status = ST_EMPTY;
        else if (it.pa >= order_count) res.status = ST_RANGE;
        else begin
          res.army = order_list[it.pa].army;
          drop_entry(int'(it.pa));
        end
      end
      OP_POP, OP_PEEK: begin
        if (order_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // earliest entry of the highest class present, else the head
          for (int want = 1; want <= NUM_PRIO; want++)
            for (int i = 0; i < order_count; i++)
              if (!found && order_list[i].cls == want) begin
                sel   = i;
                found = 1'b1;
              end
          res.tag  = order_list[sel].tag;
          res.cls  = order_list[sel].cls;
          res.army = order_list[sel].army;
          if (it.kind == OP_POP) drop_entry(sel);
        end
      end
      OP_SWAP: begin
        if (order_count == 0) res.status = ST_EMPTY;
        else if (it.pa >= order_count || it.pb >= order_count) res.status = ST_RANGE;
        else begin
          tmp                = order_list[it.pa];
          order_list[it.pa]  = order_list[it.pb];
          order_list[it.pb]  = tmp;
        end
      end
      default: ;
    endcase
    res.occ = 5'(order_count);
    return res;
  endfunction

  // offer one item, wait for it to be taken, then record its result
  task automatic offer_order(input order_in_t it, input bit typed, input order_res_t typed_res);
    order_res_t res;
    order_res_t want;
    in_valid_i    <= 1'b1;
    kind_i        <= it.kind;
    entry_class_i <= it.cls;
    entry_tag_i   <= it.tag;
    entry_army_i  <= it.army;
    position_a_i  <= it.pa;
    position_b_i  <= it.pb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res        = apply_order_op(it);
    want       = typed ? typed_res : res;
    expected_q = {expected_q, want};
    items_sent++;
    case (res.status)
      ST_FULL:  full_hits++;
      ST_EMPTY: empty_hits++;
      ST_RANGE: range_hits++;
      default: ;
    endcase
    // random gap before the next item
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // hold the sender off until every pending result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input order_res_t want,
                                 input order_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at cycle %0d: ", what, cycle_count,
               "expected st=%0d tag=%h cls=%0d army=%h occ=%0d, ",
               want.status, want.tag, want.cls, want.army, want.occ,
               "got st=%0d tag=%h cls=%0d army=%h occ=%0d",
               got.status, got.tag, got.cls, got.army, got.occ);
  endtask

  // receiver stall: random, or one long hold-off on request
  always @(posedge clk_i) begin
    if (stall_hold_req) begin
      hold_left      = LONG_HOLD;
      stall_hold_req = 1'b0;
      long_holds++;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    order_res_t got;
    order_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status: status_o, tag: out_tag_o, cls: out_class_o,
              army: out_army_o, occ: occupancy_o};
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status || got.tag !== want.tag || got.cls !== want.cls ||
            got.army !== want.army || got.occ !== want.occ)
          report_mismatch("field", want, got);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    order_in_t  item;
    order_res_t typed_res;
    int         r;
    bit         filling;
    filling = 1'b1;

    // directed table: kind, class, tag, army, pos a, pos b, repeats, typed, status, occupancy
    dir_rows[0]  = '{OP_POP,    2'd0, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b1, ST_EMPTY, 5'd0};
    dir_rows[1]  = '{OP_PEEK,   2'd0, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b1, ST_EMPTY, 5'd0};
    dir_rows[2]  = '{OP_REMOVE, 2'd0, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b1, ST_EMPTY, 5'd0};
    dir_rows[3]  = '{OP_SWAP,   2'd0, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b1, ST_EMPTY, 5'd0};
    dir_rows[4]  = '{OP_NOP_HI, 2'd3, 16'hffff, 16'hffff, 4'd15, 4'd15, 5'd1,  1'b1, ST_OK,    5'd0};
    dir_rows[5]  = '{OP_APPEND, 2'd0, 16'hffff, 16'hffff, 4'd15, 4'd15, 5'd1,  1'b1, ST_OK,    5'd1};
    dir_rows[6]  = '{OP_APPEND, 2'd3, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b1, ST_OK,    5'd2};
    dir_rows[7]  = '{OP_APPEND, 2'd2, 16'h1234, 16'h00ff, 4'd0,  4'd0,  5'd1,  1'b1, ST_OK,    5'd3};
    dir_rows[8]  = '{OP_APPEND, 2'd1, 16'h8000, 16'h0001, 4'd0,  4'd0,  5'd1,  1'b1, ST_OK,    5'd4};
    dir_rows[9]  = '{OP_APPEND, 2'd1, 16'h7fff, 16'h8000, 4'd0,  4'd0,  5'd1,  1'b1, ST_OK,    5'd5};
    dir_rows[10] = '{OP_PEEK,   2'd0, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b0, ST_OK,    5'd0};
    dir_rows[11] = '{OP_REMOVE, 2'd0, 16'h0000, 16'h0000, 4'd15, 4'd0,  5'd1,  1'b1, ST_RANGE, 5'd5};
    dir_rows[12] = '{OP_REMOVE, 2'd0, 16'h0000, 16'h0000, 4'd5,  4'd0,  5'd1,  1'b1, ST_RANGE, 5'd5};
    dir_rows[13] = '{OP_SWAP,   2'd0, 16'h0000, 16'h0000, 4'd0,  4'd15, 5'd1,  1'b1, ST_RANGE, 5'd5};
    dir_rows[14] = '{OP_SWAP,   2'd0, 16'h0000, 16'h0000, 4'd15, 4'd0,  5'd1,  1'b1, ST_RANGE, 5'd5};
    dir_rows[15] = '{OP_SWAP,   2'd0, 16'h0000, 16'h0000, 4'd2,  4'd2,  5'd1,  1'b1, ST_OK,    5'd5};
    dir_rows[16] = '{OP_SWAP,   2'd0, 16'h0000, 16'h0000, 4'd0,  4'd4,  5'd1,  1'b0, ST_OK,    5'd0};
    dir_rows[17] = '{OP_POP,    2'd0, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b0, ST_OK,    5'd0};
    dir_rows[18] = '{OP_REMOVE, 2'd0, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b0, ST_OK,    5'd0};
    dir_rows[19] = '{OP_APPEND, 2'd0, 16'hab00, 16'h5a5a, 4'd0,  4'd0,  5'd13, 1'b0, ST_OK,    5'd0};
    dir_rows[20] = '{OP_APPEND, 2'd3, 16'hffff, 16'hffff, 4'd0,  4'd0,  5'd1,  1'b1, ST_FULL,  5'd16};
    dir_rows[21] = '{OP_SWAP,   2'd0, 16'h0000, 16'h0000, 4'd0,  4'd15, 5'd1,  1'b0, ST_OK,    5'd0};
    dir_rows[22] = '{OP_REMOVE, 2'd0, 16'h0000, 16'h0000, 4'd15, 4'd0,  5'd1,  1'b0, ST_OK,    5'd0};
    dir_rows[23] = '{OP_POP,    2'd0, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b0, ST_OK,    5'd0};
    dir_rows[24] = '{OP_PEEK,   2'd0, 16'h0000, 16'h0000, 4'd0,  4'd0,  5'd1,  1'b0, ST_OK,    5'd0};

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        item.kind = dir_rows[i].kind;
        item.cls  = dir_rows[i].cls ^ 2'(k);
        item.tag  = dir_rows[i].tag + 16'(k);
        item.army = dir_rows[i].army;
        item.pa   = dir_rows[i].pa;
        item.pb   = dir_rows[i].pb;
        typed_res        = '0;
        typed_res.status = dir_rows[i].exp_status;
        typed_res.occ    = dir_rows[i].exp_occ;
        offer_order(item, dir_rows[i].typed, typed_res);
      end
    end

    // random part in three idle phases
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        drain_results();
        sender_idle_pct = 57;
        recv_idle_pct   = 24;
      end
      if (n == 2 * RAND_ITEMS / 3) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        stall_hold_req  = 1'b1;
      end

      // alternate between filling and draining the list
      if (order_count == 0) filling = 1'b1;
      else if (order_count == QDEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if ($urandom_range(0, 59) == 0) filling = !filling;

      r = $urandom_range(0, 99);
      if (r < (filling ? 50 : 18))      item.kind = OP_APPEND;
      else if (r < (filling ? 60 : 38)) item.kind = OP_REMOVE;
      else if (r < (filling ? 70 : 62)) item.kind = OP_POP;
      else if (r < 78)                  item.kind = OP_PEEK;
      else if (r < 97)                  item.kind = OP_SWAP;
      else                              item.kind = 3'($urandom_range(OP_NOP_LO, OP_NOP_HI));

      item.cls = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) item.tag = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      else item.tag = 16'($urandom);
      if ($urandom_range(0, 7) == 0) item.army = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      else item.army = 16'($urandom);

      // positions mostly inside the list, sometimes anywhere
      if (order_count > 0 && $urandom_range(0, 9) < 8)
        item.pa = 4'($urandom_range(0, order_count - 1));
      else
        item.pa = 4'($urandom_range(0, QDEPTH - 1));
      if (order_count > 0 && $urandom_range(0, 9) < 8)
        item.pb = 4'($urandom_range(0, order_count - 1));
      else
        item.pb = 4'($urandom_range(0, QDEPTH - 1));

      offer_order(item, 1'b0, '0);
    end

    // wind down
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("orders sent %0d, results checked %0d, mismatches %0d", items_sent, results_seen,
             mismatches);
    $display("rejections seen: full %0d, empty %0d, out of range %0d; long output holds %0d",
             full_hits, empty_hits, range_hits, long_holds);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
